>>> hdl/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = 8;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int PIXEL_W      = 32;
    localparam int ENTRY_W      = COLOR_W + PIXEL_W;
    localparam int DIST_W       = 10;

    localparam logic [DIST_W-1:0] DIST_START = 10'h300;
    localparam logic [IDX_W-1:0]  LAST_ADDR  = IDX_W'(PALETTE_SIZE - 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic capture;
        logic write;
        logic read;
    } nps_cmd_t;

    typedef struct packed {
        logic last_addr;
    } nps_sts_t;

endpackage

>>> hdl/nps_ram.sv
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/nps_datapath.sv
`timescale 1ns / 1ps

module nps_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nps_pkg::nps_cmd_t                   cmd,
    output nps_pkg::nps_sts_t                   sts,
    input  logic [nps_pkg::IDX_W-1:0]           entry_index,
    input  logic [nps_pkg::CHAN_W-1:0]          red,
    input  logic [nps_pkg::CHAN_W-1:0]          green,
    input  logic [nps_pkg::CHAN_W-1:0]          blue,
    input  logic [nps_pkg::PIXEL_W-1:0]         pixel_value,
    output logic [nps_pkg::IDX_W-1:0]           best_index,
    output logic [nps_pkg::PIXEL_W-1:0]         best_pixel,
    output logic [nps_pkg::DIST_W-1:0]          best_distance
);

    import nps_pkg::*;

    logic [PALETTE_SIZE-1:0] valid_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    pend_reg;
    logic                    vld_rd_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [CHAN_W-1:0]       q_red_reg;
    logic [CHAN_W-1:0]       q_green_reg;
    logic [CHAN_W-1:0]       q_blue_reg;
    logic [DIST_W-1:0]       best_dist_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [PIXEL_W-1:0]      best_pix_reg;

    logic [IDX_W-1:0]        ram_addr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [ENTRY_W-1:0]      entry;
    logic [CHAN_W-1:0]       e_red;
    logic [CHAN_W-1:0]       e_green;
    logic [CHAN_W-1:0]       e_blue;
    logic [CHAN_W-1:0]       d_red;
    logic [CHAN_W-1:0]       d_green;
    logic [CHAN_W-1:0]       d_blue;
    logic [DIST_W-1:0]       cand_dist;

    assign ram_addr  = cmd.write ? entry_index : addr_reg;
    assign ram_wdata = {red, green, blue, pixel_value};

    nps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .re    (cmd.read),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // never-written entries read as black with a zero pixel
    assign entry   = vld_rd_reg ? ram_rdata : '0;
    assign e_red   = entry[PIXEL_W+2*CHAN_W +: CHAN_W];
    assign e_green = entry[PIXEL_W+CHAN_W +: CHAN_W];
    assign e_blue  = entry[PIXEL_W +: CHAN_W];

    assign d_red   = (q_red_reg   > e_red)   ? q_red_reg   - e_red   : e_red   - q_red_reg;
    assign d_green = (q_green_reg > e_green) ? q_green_reg - e_green : e_green - q_green_reg;
    assign d_blue  = (q_blue_reg  > e_blue)  ? q_blue_reg  - e_blue  : e_blue  - q_blue_reg;
    assign cand_dist = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.read;
            if (cmd.write)
            begin
                valid_reg[entry_index] <= 1'b1;
            end
            if (cmd.capture)
            begin
                addr_reg <= '0;
            end
            else if (cmd.read)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            vld_rd_reg <= valid_reg[addr_reg];
            rd_idx_reg <= addr_reg;
        end
        if (cmd.capture)
        begin
            q_red_reg     <= red;
            q_green_reg   <= green;
            q_blue_reg    <= blue;
            best_dist_reg <= DIST_START;
            best_idx_reg  <= '0;
            best_pix_reg  <= '0;
        end
        else if (pend_reg && (cand_dist < best_dist_reg))
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= rd_idx_reg;
            best_pix_reg  <= entry[PIXEL_W-1:0];
        end
    end

    assign sts.last_addr = (addr_reg == LAST_ADDR);
    assign best_index    = best_idx_reg;
    assign best_pixel    = best_pix_reg;
    assign best_distance = best_dist_reg;

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read || pend_reg) |-> !cmd.write)
        else $error("palette write during scan");

    a_capture_not_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.read && !pend_reg)
        else $error("query captured while scan in flight");

endmodule

>>> hdl/nps_ctrl.sv
`timescale 1ns / 1ps

module nps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    output logic              busy,
    output logic              done,
    output nps_pkg::nps_cmd_t cmd,
    input  nps_pkg::nps_sts_t sts
);

    import nps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept      = start && !busy_reg;
    assign cmd.capture = accept && (op == OP_QUERY);
    assign cmd.write   = accept && (op == OP_WRITE);
    assign cmd.read    = (state_reg == S_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        state_reg <= S_SCAN;
                        busy_reg  <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (sts.last_addr)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_DONE;
                    done_reg  <= 1'b1;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> busy_reg)
        else $error("result strobe while idle");

endmodule

>>> hdl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Nearest palette color search (sum of absolute RGB differences).
//
// Command channel: drive op, entry_index, red, green, blue, pixel_value and
// raise start; the transfer happens at a clock edge where start is high and
// busy is low.
// A write (op 0) stores the color and pixel value of one entry in that same
// cycle; busy stays low and another command may follow at once.
// A query (op 1) raises busy and scans all 256 entries, one per cycle, from
// a single-port palette RAM. done rises after the flush state that lets the
// last entry be compared, and is high for exactly one cycle with best_index,
// best_pixel and best_distance; the lowest index wins a tie. busy drops the
// cycle after done. The single RAM read port serves the whole scan, so a new
// query is accepted only after busy drops.
// The receiver cannot stall; it must take the result in the done cycle.
// Reset clears the whole palette to black with zero pixel values at once
// through per-entry valid bits; no clearing pass is needed.

module nearest_palette_color_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [nps_pkg::IDX_W-1:0]     entry_index,
    input  logic [nps_pkg::CHAN_W-1:0]    red,
    input  logic [nps_pkg::CHAN_W-1:0]    green,
    input  logic [nps_pkg::CHAN_W-1:0]    blue,
    input  logic [nps_pkg::PIXEL_W-1:0]   pixel_value,
    output logic                          done,
    output logic [nps_pkg::IDX_W-1:0]     best_index,
    output logic [nps_pkg::PIXEL_W-1:0]   best_pixel,
    output logic [nps_pkg::DIST_W-1:0]    best_distance
);

    import nps_pkg::*;

    nps_cmd_t cmd;
    nps_sts_t sts;

    nps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    nps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .pixel_value   (pixel_value),
        .best_index    (best_index),
        .best_pixel    (best_pixel),
        .best_distance (best_distance)
    );

endmodule

>>> tb/sv/nearest_color_checker.sv
`timescale 1ns / 1ps

module nearest_color_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         op,
    input  logic [nps_pkg::IDX_W-1:0]    entry_index,
    input  logic [nps_pkg::CHAN_W-1:0]   red,
    input  logic [nps_pkg::CHAN_W-1:0]   green,
    input  logic [nps_pkg::CHAN_W-1:0]   blue,
    input  logic [nps_pkg::PIXEL_W-1:0]  pixel_value,
    input  logic                         done,
    input  logic [nps_pkg::IDX_W-1:0]    best_index,
    input  logic [nps_pkg::PIXEL_W-1:0]  best_pixel,
    input  logic [nps_pkg::DIST_W-1:0]   best_distance,
    output int                           mismatches,
    output int                           matches_pending
);

    import nps_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [PIXEL_W-1:0] pix;
        logic [DIST_W-1:0]  dist_val;
    } match_t;

    logic [COLOR_W-1:0] shadow_color [PALETTE_SIZE];
    logic [PIXEL_W-1:0] shadow_pixel [PALETTE_SIZE];
    match_t             expected_matches [$];
    int                 fail_total = 0;
    int                 pending_count = 0;

    assign mismatches      = fail_total;
    assign matches_pending = pending_count;

    initial
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            shadow_color[i] = '0;
            shadow_pixel[i] = '0;
        end
    end

    function automatic int chan_dist(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic match_t predict_match(input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
        match_t m;
        int     d;
        int     best;
        int     best_at;
        best    = int'(DIST_START);
        best_at = 0;
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            d = chan_dist(r, shadow_color[i][23:16])
              + chan_dist(g, shadow_color[i][15:8])
              + chan_dist(b, shadow_color[i][7:0]);
            if (d < best)
            begin
                best    = d;
                best_at = i;
            end
        end
        m.idx      = best_at[IDX_W-1:0];
        m.pix      = shadow_pixel[best_at];
        m.dist_val = best[DIST_W-1:0];
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge clk)
    begin
        match_t want;
        int     delta;
        delta = 0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (op == OP_WRITE)
                begin
                    shadow_color[entry_index] = {red, green, blue};
                    shadow_pixel[entry_index] = pixel_value;
                end
                else
                begin
                    expected_matches.push_back(predict_match(red, green, blue));
                    delta++;
                end
            end
            if (done)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch($sformatf("unexpected result: index %0d pixel %08h dist %0d",
                                              best_index, best_pixel, best_distance));
                else
                begin
                    want = expected_matches.pop_front();
                    delta--;
                    if (best_index !== want.idx)
                        report_mismatch($sformatf("best_index: got %0d, expected %0d",
                                                  best_index, want.idx));
                    if (best_pixel !== want.pix)
                        report_mismatch($sformatf("best_pixel: got %08h, expected %08h",
                                                  best_pixel, want.pix));
                    if (best_distance !== want.dist_val)
                        report_mismatch($sformatf("best_distance: got %0d, expected %0d",
                                                  best_distance, want.dist_val));
                end
            end
            pending_count <= pending_count + delta;
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import nps_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1130;
    localparam int QUIET_FIRST    = 400;
    localparam int QUIET_LAST     = 700;
    localparam int DRAIN_AT       = 800;
    localparam int TAIL_CYCLES    = 300;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               op          = OP_WRITE;
    logic [IDX_W-1:0]   entry_index = '0;
    logic [CHAN_W-1:0]  red         = '0;
    logic [CHAN_W-1:0]  green       = '0;
    logic [CHAN_W-1:0]  blue        = '0;
    logic [PIXEL_W-1:0] pixel_value = '0;
    logic               busy;
    logic               done;
    logic [IDX_W-1:0]   best_index;
    logic [PIXEL_W-1:0] best_pixel;
    logic [DIST_W-1:0]  best_distance;
    int                 mismatches;
    int                 matches_pending;
    int                 stall_cycles = 0;
    logic [COLOR_W-1:0] written_color [PALETTE_SIZE];

    always #5 clk = ~clk;

    nearest_palette_color_search u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .pixel_value   (pixel_value),
        .done          (done),
        .best_index    (best_index),
        .best_pixel    (best_pixel),
        .best_distance (best_distance)
    );

    nearest_color_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .entry_index     (entry_index),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .pixel_value     (pixel_value),
        .done            (done),
        .best_index      (best_index),
        .best_pixel      (best_pixel),
        .best_distance   (best_distance),
        .mismatches      (mismatches),
        .matches_pending (matches_pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic o, input logic [IDX_W-1:0] idx,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic [PIXEL_W-1:0] pix);
        start       <= 1'b1;
        op          <= o;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        pixel_value <= pix;
        if (o == OP_WRITE)
            written_color[idx] = {r, g, b};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (matches_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] ch);
        int v;
        v = int'(ch) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[CHAN_W-1:0];
    endfunction

    task automatic random_item();
        int                 kind;
        int                 flavor;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   pick;
        logic [COLOR_W-1:0] c;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        kind   = $urandom_range(0, 99);
        flavor = $urandom_range(0, 3);
        idx    = IDX_W'($urandom_range(0, 255));
        c      = COLOR_W'($urandom);
        r      = c[23:16];
        g      = c[15:8];
        b      = c[7:0];
        if (kind < 60)
        begin
            // coarse colors force duplicate entries and ties
            if (flavor == 0)
            begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            send_item(OP_WRITE, idx, r, g, b, $urandom);
        end
        else
        begin
            pick = IDX_W'($urandom_range(0, PALETTE_SIZE - 1));
            c    = written_color[pick];
            if (flavor == 1)
            begin
                r = c[23:16];
                g = c[15:8];
                b = c[7:0];
            end
            else if (flavor >= 2)
            begin
                r = nudge(c[23:16]);
                g = nudge(c[15:8]);
                b = nudge(c[7:0]);
            end
            send_item(OP_QUERY, idx, r, g, b, $urandom);
        end
    endtask

    initial
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
            written_color[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_QUERY, 8'h5a, 8'd10, 8'd20, 8'd30, 32'hdeadbeef);
        send_item(OP_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 32'h00000000);
        send_item(OP_QUERY, 8'hff, 8'h00, 8'h00, 8'h00, 32'hffffffff);
        send_item(OP_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff);
        send_item(OP_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 32'h00000000);
        send_item(OP_WRITE, 8'h00, 8'hff, 8'hff, 8'hff, 32'h12345678);
        send_item(OP_QUERY, 8'h11, 8'hff, 8'hff, 8'hff, 32'h0);
        send_item(OP_WRITE, 8'd7, 8'd100, 8'd50, 8'd25, 32'ha5a5a5a5);
        send_item(OP_WRITE, 8'd3, 8'd100, 8'd50, 8'd25, 32'h5a5a5a5a);
        send_item(OP_QUERY, 8'h00, 8'd100, 8'd50, 8'd25, 32'h0);
        send_item(OP_QUERY, 8'h00, 8'd101, 8'd49, 8'd26, 32'h0);
        send_item(OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
        send_item(OP_WRITE, 8'd1, 8'h80, 8'h80, 8'h80, 32'h00000001);
        send_item(OP_WRITE, 8'd128, 8'h00, 8'hff, 8'h00, 32'h80000000);
        send_item(OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
        send_item(OP_QUERY, 8'h00, 8'h00, 8'hff, 8'h00, 32'h0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == DRAIN_AT)
                drain_results();
            else if ((n < QUIET_FIRST || n >= QUIET_LAST) && $urandom_range(0, 99) < 10)
                hold_off($urandom_range(1, 12));
            random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
